>>> rtl/core/mct_pkg.sv
`default_nettype none

package mct_pkg;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_TRAP  = 3'd2;
  localparam logic [2:0] OP_MRET  = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [2:0] OP_TIMER = 3'd5;

  localparam logic [11:0] ADDR_SATP     = 12'h180;
  localparam logic [11:0] ADDR_MSTATUS  = 12'h300;
  localparam logic [11:0] ADDR_MTVEC    = 12'h305;
  localparam logic [11:0] ADDR_MSCRATCH = 12'h340;
  localparam logic [11:0] ADDR_MEPC     = 12'h341;
  localparam logic [11:0] ADDR_MCAUSE   = 12'h342;

  localparam logic [31:0] MSTATUS_RESET  = 32'h0000_1800;
  localparam int          MIE_IDX        = 3;
  localparam int          MPIE_IDX       = 7;
  localparam logic [31:0] IRQ_TIMER_CODE = 32'h8000_0007;
  localparam logic [31:0] INTR_NONE      = 32'hFFFF_FFFF;
  localparam logic [31:0] PC_STEP        = 32'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] csr_addr;
    logic [31:0] write_data;
    logic [31:0] trap_cause;
    logic [31:0] trap_pc;
  } req_item_t;

  typedef struct packed {
    logic [31:0] result_data;
    logic        bad_csr;
    logic        intr_taken;
  } rsp_item_t;

endpackage

`default_nettype wire

>>> rtl/core/mct_chan_if.sv
`default_nettype none

interface mct_req_if;
  import mct_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mct_rsp_if;
  import mct_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mct_csr_file.sv
`default_nettype none

module mct_csr_file (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               exec,
  input  wire mct_pkg::req_item_t item,
  output mct_pkg::rsp_item_t      result
);
  import mct_pkg::*;

  logic [31:0] satp;
  logic [31:0] mstatus;
  logic [31:0] mtvec;
  logic [31:0] mscratch;
  logic [31:0] mepc;
  logic [31:0] mcause;
  logic        timer_pending;

  logic [31:0] satp_next;
  logic [31:0] mstatus_next;
  logic [31:0] mtvec_next;
  logic [31:0] mscratch_next;
  logic [31:0] mepc_next;
  logic [31:0] mcause_next;
  logic        timer_pending_next;

  logic [31:0] rd_data;
  logic        hit;

  always_comb begin
    hit     = 1'b1;
    rd_data = '0;
    case (item.csr_addr)
      ADDR_SATP:     rd_data = satp;
      ADDR_MSTATUS:  rd_data = mstatus;
      ADDR_MTVEC:    rd_data = mtvec;
      ADDR_MSCRATCH: rd_data = mscratch;
      ADDR_MEPC:     rd_data = mepc;
      ADDR_MCAUSE:   rd_data = mcause;
      default:       hit = 1'b0;
    endcase
  end

  always_comb begin
    satp_next          = satp;
    mstatus_next       = mstatus;
    mtvec_next         = mtvec;
    mscratch_next      = mscratch;
    mepc_next          = mepc;
    mcause_next        = mcause;
    timer_pending_next = timer_pending;
    result             = '0;
    case (item.op)
      OP_READ: begin
        result.result_data = rd_data;
        result.bad_csr     = ~hit;
      end
      OP_WRITE: begin
        result.bad_csr = ~hit;
        case (item.csr_addr)
          ADDR_SATP:     satp_next     = item.write_data;
          ADDR_MSTATUS:  mstatus_next  = item.write_data;
          ADDR_MTVEC:    mtvec_next    = item.write_data;
          ADDR_MSCRATCH: mscratch_next = item.write_data;
          ADDR_MEPC:     mepc_next     = item.write_data;
          ADDR_MCAUSE:   mcause_next   = item.write_data;
          default:       ;
        endcase
      end
      OP_TRAP: begin
        mstatus_next[MPIE_IDX] = mstatus[MIE_IDX];
        mstatus_next[MIE_IDX]  = 1'b0;
        mcause_next            = item.trap_cause;
        mepc_next              = item.trap_pc + PC_STEP;
        result.result_data     = mtvec;
      end
      OP_MRET: begin
        mstatus_next[MIE_IDX]  = mstatus[MPIE_IDX];
        mstatus_next[MPIE_IDX] = 1'b1;
        result.result_data     = mepc;
      end
      OP_QUERY: begin
        if (timer_pending && mstatus[MIE_IDX]) begin
          timer_pending_next = 1'b0;
          result.result_data = IRQ_TIMER_CODE;
          result.intr_taken  = 1'b1;
        end else begin
          result.result_data = INTR_NONE;
        end
      end
      OP_TIMER: timer_pending_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      satp          <= '0;
      mstatus       <= MSTATUS_RESET;
      mtvec         <= '0;
      mscratch      <= '0;
      mepc          <= '0;
      mcause        <= '0;
      timer_pending <= 1'b0;
    end else if (exec) begin
      satp          <= satp_next;
      mstatus       <= mstatus_next;
      mtvec         <= mtvec_next;
      mscratch      <= mscratch_next;
      mepc          <= mepc_next;
      mcause        <= mcause_next;
      timer_pending <= timer_pending_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/machine_csr_trap_unit.sv
// Items pass the input register, then the result register, to the output channel.
// Throughput: one item per cycle unless the output stalls; the CSR update and the
// result are formed in one pass between the input register and the result register.
// Reset clears the CSRs to their reset values (mstatus 0x1800, all others zero),
// clears the pending timer flag and empties both pipeline registers.
`default_nettype none

module machine_csr_trap_unit (
  input  wire logic clk,
  input  wire logic rst,
  mct_req_if.sink   req,
  mct_rsp_if.source rsp
);
  import mct_pkg::*;

  logic      req_valid_q;
  req_item_t req_item_q;
  logic      advance;
  rsp_item_t exec_result;
  logic      rsp_valid_q;
  rsp_item_t rsp_item_q;

  assign advance   = req_valid_q && (!rsp_valid_q || rsp.ready);
  assign req.ready = !req_valid_q || advance;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_item_q;

  mct_csr_file u_csr_file (
    .clk    (clk),
    .rst    (rst),
    .exec   (advance),
    .item   (req_item_q),
    .result (exec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_item_q <= req.data;
    end
    if (advance) begin
      rsp_item_q <= exec_result;
    end
  end

endmodule

`default_nettype wire

>>> dv/machine_csr_trap_unit_check.sv
`timescale 1ns / 1ps

module csr_trap_check
  import mct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mct_req_if        req,
  mct_rsp_if        rsp,
  output int        fail_count,
  output int        due_count
);

  logic [31:0] satp_q;
  logic [31:0] mstatus_q;
  logic [31:0] mtvec_q;
  logic [31:0] mscratch_q;
  logic [31:0] mepc_q;
  logic [31:0] mcause_q;
  logic        timer_q;

  rsp_item_t answers_due[$];
  rsp_item_t want;

  initial begin
    fail_count = 0;
    due_count = 0;
  end

  function automatic rsp_item_t csr_trap_predict(input req_item_t it);
    rsp_item_t r;
    r = '0;
    case (it.op)
      OP_READ: begin
        case (it.csr_addr)
          ADDR_SATP:     r.result_data = satp_q;
          ADDR_MSTATUS:  r.result_data = mstatus_q;
          ADDR_MTVEC:    r.result_data = mtvec_q;
          ADDR_MSCRATCH: r.result_data = mscratch_q;
          ADDR_MEPC:     r.result_data = mepc_q;
          ADDR_MCAUSE:   r.result_data = mcause_q;
          default:       r.bad_csr = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (it.csr_addr)
          ADDR_SATP:     satp_q = it.write_data;
          ADDR_MSTATUS:  mstatus_q = it.write_data;
          ADDR_MTVEC:    mtvec_q = it.write_data;
          ADDR_MSCRATCH: mscratch_q = it.write_data;
          ADDR_MEPC:     mepc_q = it.write_data;
          ADDR_MCAUSE:   mcause_q = it.write_data;
          default:       r.bad_csr = 1'b1;
        endcase
      end
      OP_TRAP: begin
        mstatus_q[MPIE_IDX] = mstatus_q[MIE_IDX];
        mstatus_q[MIE_IDX] = 1'b0;
        mcause_q = it.trap_cause;
        mepc_q = it.trap_pc + PC_STEP;
        r.result_data = mtvec_q;
      end
      OP_MRET: begin
        mstatus_q[MIE_IDX] = mstatus_q[MPIE_IDX];
        mstatus_q[MPIE_IDX] = 1'b1;
        r.result_data = mepc_q;
      end
      OP_QUERY: begin
        if (timer_q && mstatus_q[MIE_IDX]) begin
          timer_q = 1'b0;
          r.result_data = IRQ_TIMER_CODE;
          r.intr_taken = 1'b1;
        end else begin
          r.result_data = INTR_NONE;
        end
      end
      OP_TIMER: timer_q = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      satp_q = '0;
      mstatus_q = MSTATUS_RESET;
      mtvec_q = '0;
      mscratch_q = '0;
      mepc_q = '0;
      mcause_q = '0;
      timer_q = 1'b0;
      answers_due.delete();
    end else begin
      // A result leaving at this edge belongs to an older item, so it is checked first.
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $error("result with no item outstanding: %h", rsp.data);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (rsp.data.result_data !== want.result_data) begin
            $error("result_data: expected %h, got %h", want.result_data, rsp.data.result_data);
            fail_count++;
          end
          if (rsp.data.bad_csr !== want.bad_csr) begin
            $error("bad_csr: expected %b, got %b", want.bad_csr, rsp.data.bad_csr);
            fail_count++;
          end
          if (rsp.data.intr_taken !== want.intr_taken) begin
            $error("intr_taken: expected %b, got %b", want.intr_taken, rsp.data.intr_taken);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        answers_due.push_back(csr_trap_predict(req.data));
      end
    end
    due_count <= answers_due.size();
  end

endmodule

>>> dv/machine_csr_trap_unit_test.sv
`timescale 1ns / 1ps

module machine_csr_trap_unit_test;
  import mct_pkg::*;

  localparam int ITEM_TARGET = 1300;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [11:0] ADDR_NONE_HI = 12'hFFF;
  localparam logic [11:0] ADDR_NONE_LO = 12'h000;

  logic clk;
  logic rst;
  int   fail_count;
  int   due_count;
  int   sent;
  int   burst_left;
  int   idle_cycles;

  mct_req_if req_ch ();
  mct_rsp_if rsp_ch ();

  machine_csr_trap_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  csr_trap_check check_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [11:0] pick_csr();
    logic [11:0] a;
    case ($urandom_range(0, 5))
      0:       a = ADDR_SATP;
      1:       a = ADDR_MSTATUS;
      2:       a = ADDR_MTVEC;
      3:       a = ADDR_MSCRATCH;
      4:       a = ADDR_MEPC;
      default: a = ADDR_MCAUSE;
    endcase
    return a;
  endfunction

  function automatic req_item_t mk(input logic [2:0] op, input logic [11:0] addr,
                                   input logic [31:0] wd, input logic [31:0] cause,
                                   input logic [31:0] pc);
    req_item_t it;
    it.op = op;
    it.csr_addr = addr;
    it.write_data = wd;
    it.trap_cause = cause;
    it.trap_pc = pc;
    return it;
  endfunction

  task automatic send(input req_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic simple(input logic [2:0] op, input logic [11:0] addr, input logic [31:0] wd);
    send(mk(op, addr, wd, $urandom, $urandom));
  endtask

  task automatic random_episode();
    logic [31:0] mie_mask;
    mie_mask = 32'h1 << MIE_IDX;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // A full handler round trip with random content.
        if ($urandom_range(0, 1)) simple(OP_WRITE, ADDR_MTVEC, $urandom);
        if ($urandom_range(0, 3) != 0) simple(OP_WRITE, ADDR_MSTATUS, $urandom | mie_mask);
        if ($urandom_range(0, 3) != 0) simple(OP_TIMER, 12'($urandom), $urandom);
        simple(OP_QUERY, 12'($urandom), $urandom);
        send(mk(OP_TRAP, 12'($urandom), $urandom, $urandom, $urandom));
        simple(OP_READ, pick_csr(), $urandom);
        if ($urandom_range(0, 2) == 0) simple(OP_WRITE, ADDR_MEPC, $urandom);
        simple(OP_MRET, 12'($urandom), $urandom);
        simple(OP_QUERY, 12'($urandom), $urandom);
      end
      4, 5, 6: simple($urandom_range(0, 1) ? OP_READ : OP_WRITE, pick_csr(), $urandom);
      7: simple(3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)), $urandom);
      8: simple($urandom_range(0, 1) ? OP_TRAP : OP_MRET, 12'($urandom), $urandom);
      default: begin
        simple(OP_TIMER, 12'($urandom), $urandom);
        simple(OP_QUERY, 12'($urandom), $urandom);
      end
    endcase
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    for (int stretch = 0; ; stretch++) begin
      if (stretch == 3) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        automatic int mode = $urandom_range(0, 3);
        automatic int len = $urandom_range(5, 60);
        repeat (len) begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("machine_csr_trap_unit_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    simple(OP_READ, ADDR_SATP, $urandom);
    simple(OP_READ, ADDR_MSTATUS, $urandom);
    simple(OP_READ, ADDR_MTVEC, $urandom);
    simple(OP_READ, ADDR_MSCRATCH, $urandom);
    simple(OP_READ, ADDR_MEPC, $urandom);
    simple(OP_READ, ADDR_MCAUSE, $urandom);
    simple(OP_READ, ADDR_NONE_HI, $urandom);
    simple(OP_WRITE, ADDR_NONE_LO, 32'hFFFF_FFFF);
    simple(OP_WRITE, ADDR_SATP, 32'hFFFF_FFFF);
    simple(OP_WRITE, ADDR_MTVEC, 32'h8000_0100);
    simple(OP_WRITE, ADDR_MSCRATCH, 32'hFFFF_FFFF);
    simple(OP_WRITE, ADDR_MCAUSE, 32'hFFFF_FFFF);
    simple(OP_QUERY, 12'($urandom), $urandom);
    simple(OP_TIMER, 12'($urandom), $urandom);
    simple(OP_TIMER, 12'($urandom), $urandom);
    simple(OP_QUERY, 12'($urandom), $urandom);
    simple(OP_WRITE, ADDR_MSTATUS, 32'hFFFF_FFFF);
    simple(OP_QUERY, 12'($urandom), $urandom);
    simple(OP_QUERY, 12'($urandom), $urandom);
    send(mk(OP_TRAP, 12'($urandom), $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFC));
    simple(OP_READ, ADDR_MSTATUS, $urandom);
    simple(OP_MRET, 12'($urandom), $urandom);
    simple(OP_SPARE6, 12'($urandom), $urandom);
    simple(OP_SPARE7, 12'($urandom), $urandom);
    simple(OP_READ, ADDR_MEPC, $urandom);

    while (sent < ITEM_TARGET) random_episode();

    req_ch.valid <= 1'b0;
    while (due_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("machine_csr_trap_unit_test: PASS");
    end else begin
      $display("machine_csr_trap_unit_test: FAIL");
    end
    $finish;
  end

endmodule
